[rtl/svcf_pkg.sv]
// Shared types, constants and helpers for the servo command packet framer.
// No dependencies; every other file in rtl/ imports this package.
package svcf_pkg;

	// Command kinds on the input channel
	typedef enum logic [2:0] {
		KIND_SET_LIMITS = 3'd0,
		KIND_WRITE_POS  = 3'd1,
		KIND_REG_WRITE  = 3'd2,
		KIND_ACTION     = 3'd3,
		KIND_PING       = 3'd4,
		KIND_SYNC_WRITE = 3'd5
	} kind_t;

	// Packet bytes
	localparam logic [7:0] HDR_BYTE       = 8'hFF;
	localparam logic [7:0] BCAST_ID       = 8'hFE;
	localparam logic [7:0] INS_PING       = 8'h01;
	localparam logic [7:0] INS_WRITE      = 8'h03;
	localparam logic [7:0] INS_REG_WRITE  = 8'h04;
	localparam logic [7:0] INS_ACTION     = 8'h05;
	localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
	localparam logic [7:0] ADDR_LIMITS    = 8'h06;
	localparam logic [7:0] ADDR_GOAL      = 8'h1E;
	localparam logic [7:0] SYNC_DATA_LEN  = 8'h04;
	localparam logic [7:0] LEN_WRITE      = 8'h07;
	localparam logic [7:0] LEN_SHORT      = 8'h02;
	localparam logic [7:0] LEN_SYNC       = 8'h0E;
	localparam logic [15:0] VAL_MAX       = 16'd1023;

	// Body = bytes between header and checksum (id .. last parameter)
	localparam int BODY_MAX = 15;
	localparam int HDR_LEN  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] BODY_LEN_WRITE = 4'd8;
	localparam logic [3:0] BODY_LEN_SHORT = 4'd3;
	localparam logic [3:0] BODY_LEN_SYNC  = 4'd15;

	// One framed packet waiting for the serializer
	typedef struct packed {
		logic [BODY_MAX-1:0][7:0] body;
		logic [3:0]               body_len;
	} frame_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [15:0] clamp_val(input logic [15:0] v);
		return (v > VAL_MAX) ? VAL_MAX : v;
	endfunction

endpackage

[rtl/svcf_front.sv]
// Front end: accepts commands, decodes the kind, clamps values and builds the packet body.
// Depends on svcf_pkg.
module svcf_front (
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [2:0]         kind,
	input  logic [7:0]         servo_id,
	input  logic [15:0]        first_value,
	input  logic [15:0]        second_value,
	input  logic [7:0]         other_servo_id,
	input  logic [15:0]        other_position,
	input  logic [15:0]        other_speed,
	input  svcf_pkg::q_status_t q_stat,
	output logic               push,
	output svcf_pkg::frame_t   frame
);
	import svcf_pkg::*;

	logic        kind_ok;
	logic [15:0] val_a;
	logic [15:0] val_b;

	// Clamp only for the plain write commands
	always_comb begin
		if (kind == KIND_SET_LIMITS || kind == KIND_WRITE_POS) begin
			val_a = clamp_val(first_value);
			val_b = clamp_val(second_value);
		end else begin
			val_a = first_value;
			val_b = second_value;
		end
	end

	// Decode kind into packet body
	always_comb begin
		frame   = '0;
		kind_ok = 1'b1;
		unique case (kind) inside
			KIND_SET_LIMITS, KIND_WRITE_POS, KIND_REG_WRITE: begin
				frame.body[0] = servo_id;
				frame.body[1] = LEN_WRITE;
				frame.body[2] = (kind == KIND_REG_WRITE) ? INS_REG_WRITE : INS_WRITE;
				frame.body[3] = (kind == KIND_SET_LIMITS) ? ADDR_LIMITS : ADDR_GOAL;
				frame.body[4] = val_a[7:0];
				frame.body[5] = val_a[15:8];
				frame.body[6] = val_b[7:0];
				frame.body[7] = val_b[15:8];
				frame.body_len = BODY_LEN_WRITE;
			end
			KIND_ACTION: begin
				frame.body[0] = BCAST_ID;
				frame.body[1] = LEN_SHORT;
				frame.body[2] = INS_ACTION;
				frame.body_len = BODY_LEN_SHORT;
			end
			KIND_PING: begin
				frame.body[0] = servo_id;
				frame.body[1] = LEN_SHORT;
				frame.body[2] = INS_PING;
				frame.body_len = BODY_LEN_SHORT;
			end
			KIND_SYNC_WRITE: begin
				frame.body[0]  = BCAST_ID;
				frame.body[1]  = LEN_SYNC;
				frame.body[2]  = INS_SYNC_WRITE;
				frame.body[3]  = ADDR_GOAL;
				frame.body[4]  = SYNC_DATA_LEN;
				frame.body[5]  = servo_id;
				frame.body[6]  = val_a[7:0];
				frame.body[7]  = val_a[15:8];
				frame.body[8]  = val_b[7:0];
				frame.body[9]  = val_b[15:8];
				frame.body[10] = other_servo_id;
				frame.body[11] = other_position[7:0];
				frame.body[12] = other_position[15:8];
				frame.body[13] = other_speed[7:0];
				frame.body[14] = other_speed[15:8];
				frame.body_len = BODY_LEN_SYNC;
			end
			default: kind_ok = 1'b0;
		endcase
	end

	// Undefined kinds are taken and dropped
	assign cmd_ready = !q_stat.full;
	assign push      = cmd_valid && cmd_ready && kind_ok;

endmodule

[rtl/svcf_queue.sv]
// Small register queue between the decoder and the byte serializer.
// Depends on svcf_pkg.
module svcf_queue #(
	parameter int Depth = svcf_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  svcf_pkg::frame_t           wr_frame,
	input  logic                       pop,
	output svcf_pkg::frame_t           rd_frame,
	output svcf_pkg::q_status_t        q_stat,
	output logic [$clog2(Depth+1)-1:0] count
);
	import svcf_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth+1);

	frame_t        mem_q [Depth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(Depth-1)) ? '0 : p + 1'b1;
	endfunction

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_frame;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rd_frame     = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CW'(Depth));
	assign count        = count_q;

endmodule

[rtl/svcf_back.sv]
// Back end: sends header, head packet, checksum; one byte per cycle unless stalled.
// Depends on svcf_pkg.
module svcf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  svcf_pkg::frame_t    frame,
	input  svcf_pkg::q_status_t q_stat,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_ready,
	output logic [7:0]          tx_byte,
	output logic                last_byte
);
	import svcf_pkg::*;

	logic [4:0] cnt_q;
	logic [7:0] sum_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       is_hdr;
	logic       is_chk;
	logic [4:0] body_pos;
	logic [7:0] next_byte;

	// Pick the byte for the current position
	always_comb begin
		load      = !q_stat.empty && (!valid_q || tx_ready);
		is_hdr    = (cnt_q < 5'(HDR_LEN));
		is_chk    = (cnt_q == ({1'b0, frame.body_len} + 5'(HDR_LEN)));
		body_pos  = cnt_q - 5'(HDR_LEN);
		if (is_hdr)      next_byte = HDR_BYTE;
		else if (is_chk) next_byte = ~sum_q;
		else             next_byte = frame.body[body_pos[3:0]];
	end

	assign pop = load && is_chk;

	// Position counter, running sum, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				if (is_chk) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (!is_hdr) sum_q <= sum_q + next_byte;
				end
			end else if (tx_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= is_chk;
		end
	end

	assign tx_valid  = valid_q;
	assign tx_byte   = byte_q;
	assign last_byte = last_q;

endmodule

[rtl/servo_command_packet_framer.sv]
// Top level of the servo command packet framer.
// Depends on svcf_pkg, svcf_front, svcf_queue, svcf_back.
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) takes one servo command per request:
//   kind, ids and 16-bit values. Byte channel (tx_valid/tx_ready) returns the
//   instruction packet, one byte per request, last_byte high on the checksum.
//   Packets are 6 bytes (action, ping), 11 bytes (limit/position writes) or
//   18 bytes (sync write). Kinds 6 and 7 are accepted and produce nothing.
//   A taken command is written into the queue; the serializer then loads its
//   header bytes into the byte register. Throughput: one byte per cycle while
//   tx_ready is high; the command queue (QueueDepth entries) lets the next
//   commands be accepted while a packet is still streaming.
//   Receiver stall: the byte register holds while tx_ready is low; the serializer
//   then stops, and cmd_ready drops once the queue is full.
//   Reset (arst_n low) empties the queue and drops any packet in progress.
module servo_command_packet_framer #(
	parameter int QueueDepth = svcf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  servo_id,
	input  logic [15:0] first_value,
	input  logic [15:0] second_value,
	input  logic [7:0]  other_servo_id,
	input  logic [15:0] other_position,
	input  logic [15:0] other_speed,
	output logic        tx_valid,
	input  logic        tx_ready,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);
	import svcf_pkg::*;

	localparam int CW = $clog2(QueueDepth+1);

	q_status_t     q_stat;
	frame_t        wr_frame;
	frame_t        rd_frame;
	logic          push;
	logic          pop;
	logic [CW-1:0] q_count;

	svcf_front u_front (
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.kind           (kind),
		.servo_id       (servo_id),
		.first_value    (first_value),
		.second_value   (second_value),
		.other_servo_id (other_servo_id),
		.other_position (other_position),
		.other_speed    (other_speed),
		.q_stat         (q_stat),
		.push           (push),
		.frame          (wr_frame)
	);

	svcf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (wr_frame),
		.pop      (pop),
		.rd_frame (rd_frame),
		.q_stat   (q_stat),
		.count    (q_count)
	);

	svcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (rd_frame),
		.q_stat    (q_stat),
		.pop       (pop),
		.tx_valid  (tx_valid),
		.tx_ready  (tx_ready),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QueueDepth))
		else $error("queue count above depth");

	// A valid command is held in the queue on the next cycle
	a_cmd_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && kind <= 3'(KIND_SYNC_WRITE)) |=> (q_count != '0))
		else $error("accepted command not queued");

	// Byte following the end of a packet starts a new header
	a_hdr_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && tx_ready && last_byte) |=> (!tx_valid || tx_byte == HDR_BYTE))
		else $error("packet does not start with header");

endmodule
